[rtl/lfu_pkg.sv]
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the LFU key/value cache table.
// ----------------------------------------------------------------------------
package lfu_pkg;

	localparam int KeyBits        = 32;
	localparam int ValueBits      = 32;
	localparam int UsesBits       = 32;
	localparam int CapBits        = 5;
	localparam int DefaultEntries = 16;
	localparam logic [CapBits-1:0] CapReset = CapBits'(16);

	typedef struct packed {
		logic                 req_type;
		logic [KeyBits-1:0]   lookup_key;
		logic [ValueBits-1:0] write_value;
	} req_t;

	typedef struct packed {
		logic                 hit;
		logic [ValueBits-1:0] read_value;
		logic                 evicted;
		logic [KeyBits-1:0]   evicted_key;
	} rsp_t;

	typedef struct packed {
		logic [KeyBits-1:0]   key;
		logic [ValueBits-1:0] value;
		logic [UsesBits-1:0]  uses;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_UPDATE,
		ST_SHIFT,
		ST_SDRAIN,
		ST_APPEND,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic scan_rd;
		logic evict;
		logic shift_rd;
		logic upd_wr;
		logic append_wr;
	} ctl_cmd_t;

	typedef struct packed {
		logic fill_zero;
		logic scan_last;
		logic shift_last;
		logic shift_none;
		logic hit;
		logic is_set;
		logic need_evict;
	} ctl_sts_t;

endpackage

[rtl/lfu_ctrl.sv]
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer for one transaction: scan, decide, then update, append, or shift and append.
// ----------------------------------------------------------------------------
module lfu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  lfu_pkg::ctl_sts_t sts,
	output lfu_pkg::ctl_cmd_t cmd,
	output logic              busy,
	output logic              done
);
	import lfu_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = sts.fill_zero ? ST_DECIDE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_nxt = ST_DECIDE;
			ST_DECIDE: begin
				priority if (sts.hit) begin
					state_nxt = ST_UPDATE;
				end else if (!sts.is_set) begin
					state_nxt = ST_DONE;
				end else if (sts.need_evict && !sts.shift_none) begin
					state_nxt = ST_SHIFT;
				end else begin
					state_nxt = ST_APPEND;
				end
			end
			ST_UPDATE: state_nxt = ST_DONE;
			ST_SHIFT: begin
				if (sts.shift_last) begin
					state_nxt = ST_SDRAIN;
				end
			end
			ST_SDRAIN: state_nxt = ST_APPEND;
			ST_APPEND: state_nxt = ST_DONE;
			ST_DONE:   state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_SCAN:   cmd.scan_rd = 1'b1;
			ST_DECIDE: cmd.evict = !sts.hit && sts.is_set && sts.need_evict;
			ST_UPDATE: cmd.upd_wr = 1'b1;
			ST_SHIFT:  cmd.shift_rd = 1'b1;
			ST_APPEND: cmd.append_wr = 1'b1;
			ST_DONE:   done = 1'b1;
			default: begin
			end
		endcase
	end

endmodule

[rtl/lfu_dpath.sv]
// ----------------------------------------------------------------------------
// lfu_dpath
// Entry memory, scan compare, least-used tracking, shift and append datapath.
// ----------------------------------------------------------------------------
module lfu_dpath #(
	parameter int ENTRIES = lfu_pkg::DefaultEntries
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lfu_pkg::req_t               req,
	input  lfu_pkg::ctl_cmd_t           cmd,
	output lfu_pkg::ctl_sts_t           sts,
	output lfu_pkg::rsp_t               rsp,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lfu_pkg::CapBits-1:0] cfg_data
);
	import lfu_pkg::*;

	localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CntW = $clog2(ENTRIES + 1);
	localparam int CmpW = (CntW > CapBits) ? CntW : CapBits;
	localparam logic [CmpW-1:0] EntLim = CmpW'(ENTRIES);
	localparam logic [CmpW-1:0] OneCmp = CmpW'(1);

	entry_t mem [ENTRIES];

	req_t               req_q;
	logic [CntW-1:0]    fill_q;
	logic [CapBits-1:0] cap_q;
	logic [CntW-1:0]    cnt_q;
	logic               rd_vld_s1;
	logic               rd_shift_s1;
	logic [IdxW-1:0]    rd_idx_s1;
	entry_t             rd_data_s1;
	logic               match_q;
	logic [IdxW-1:0]    match_idx_q;
	entry_t             match_ent_q;
	logic [IdxW-1:0]    min_idx_q;
	logic [UsesBits-1:0] min_uses_q;
	logic [KeyBits-1:0] min_key_q;
	logic               evicted_q;

	logic [CntW-1:0]    cnt_nxt;
	logic [CntW-1:0]    fill_m1;
	logic               rd_en;
	logic [IdxW-1:0]    rd_addr;
	logic               wr_en;
	logic [IdxW-1:0]    wr_addr;
	entry_t             wr_data;
	logic               scan_vld;
	logic [CmpW-1:0]    cap_ext;
	logic [CmpW-1:0]    eff_cap;

	assign cnt_nxt = cnt_q + 1'b1;
	assign fill_m1 = fill_q - 1'b1;
	assign rd_en   = cmd.scan_rd || cmd.shift_rd;
	assign rd_addr = cmd.shift_rd ? cnt_nxt[IdxW-1:0] : cnt_q[IdxW-1:0];
	assign scan_vld = rd_vld_s1 && !rd_shift_s1;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = match_idx_q;
		wr_data = match_ent_q;
		priority if (rd_vld_s1 && rd_shift_s1) begin
			wr_en   = 1'b1;
			wr_addr = rd_idx_s1;
			wr_data = rd_data_s1;
		end else if (cmd.upd_wr) begin
			wr_en   = 1'b1;
			wr_addr = match_idx_q;
			if (req_q.req_type) begin
				wr_data.value = req_q.write_value;
			end
			if (match_ent_q.uses != '1) begin
				wr_data.uses = match_ent_q.uses + 1'b1;
			end
		end else if (cmd.append_wr) begin
			wr_en         = 1'b1;
			wr_addr       = fill_q[IdxW-1:0];
			wr_data.key   = req_q.lookup_key;
			wr_data.value = req_q.write_value;
			wr_data.uses  = UsesBits'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CapReset;
			fill_q      <= '0;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rd_shift_s1 <= 1'b0;
			match_q     <= 1'b0;
			evicted_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			rd_vld_s1   <= rd_en;
			rd_shift_s1 <= cmd.shift_rd;
			if (cmd.load) begin
				cnt_q     <= '0;
				match_q   <= 1'b0;
				evicted_q <= 1'b0;
			end else if (cmd.evict) begin
				cnt_q     <= CntW'(min_idx_q);
				evicted_q <= 1'b1;
			end else if (cmd.scan_rd || cmd.shift_rd) begin
				cnt_q <= cnt_nxt;
			end
			if (scan_vld && (rd_data_s1.key == req_q.lookup_key)) begin
				match_q <= 1'b1;
			end
			if (cmd.evict) begin
				fill_q <= fill_m1;
			end else if (cmd.append_wr) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		rd_idx_s1 <= cnt_q[IdxW-1:0];
		if (scan_vld && !match_q && (rd_data_s1.key == req_q.lookup_key)) begin
			match_idx_q <= rd_idx_s1;
			match_ent_q <= rd_data_s1;
		end
		if (scan_vld && ((rd_idx_s1 == '0) || (rd_data_s1.uses < min_uses_q))) begin
			min_idx_q  <= rd_idx_s1;
			min_uses_q <= rd_data_s1.uses;
			min_key_q  <= rd_data_s1.key;
		end
	end

	assign cap_ext = CmpW'(cap_q);

	always_comb begin
		priority if (cap_q == '0) begin
			eff_cap = OneCmp;
		end else if (cap_ext > EntLim) begin
			eff_cap = EntLim;
		end else begin
			eff_cap = cap_ext;
		end
	end

	assign sts.fill_zero  = (fill_q == '0);
	assign sts.scan_last  = (cnt_q == fill_m1);
	assign sts.shift_last = (cnt_nxt == fill_q);
	assign sts.shift_none = (CntW'(min_idx_q) == fill_m1);
	assign sts.hit        = match_q;
	assign sts.is_set     = req_q.req_type;
	assign sts.need_evict = (fill_q != '0) && (CmpW'(fill_q) >= eff_cap);

	assign rsp.hit         = match_q;
	assign rsp.read_value  = (match_q && !req_q.req_type) ? match_ent_q.value : '0;
	assign rsp.evicted     = evicted_q;
	assign rsp.evicted_key = evicted_q ? min_key_q : '0;

	assign cfg_ready = 1'b1;

endmodule

[rtl/lfu_cache_table.sv]
// ----------------------------------------------------------------------------
// lfu_cache_table
// Least-frequently-used key/value cache with a configurable capacity.
// ----------------------------------------------------------------------------
// One transaction at a time: start is taken when busy is low, and the result
// appears on rsp for exactly one cycle with done high; there is no result
// backpressure, so the receiver must capture it in that cycle. A transaction
// runs a scan with one memory read per entry, a read drain, decide, update or
// append, and respond; a get that misses goes from decide to respond. A set
// that evicts an older entry first moves the entries above the evicted one
// down one per cycle (one read and one write of the entry memory each cycle)
// and then appends; a set that evicts the newest entry appends without moving
// any. With an empty table the scan and its drain are skipped. The next
// transaction can be taken in the cycle after done. The capacity register may
// be written only while busy is low.
// ----------------------------------------------------------------------------
module lfu_cache_table #(
	parameter int ENTRIES = lfu_pkg::DefaultEntries
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  lfu_pkg::req_t               req,
	output logic                        done,
	output lfu_pkg::rsp_t               rsp,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lfu_pkg::CapBits-1:0] cfg_data
);
	import lfu_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	lfu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	lfu_dpath #(
		.ENTRIES (ENTRIES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

endmodule

[verif/lfu_cache_table_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lfu_cache_table_test
// Self-checking testbench for the LFU key/value cache table. Directed
// transactions cover empty-table lookups, value updates and least-used
// eviction with ties. The capacity register goes through 0, 1, 16, 31 and
// values in between, including writes below the current fill. Random
// transactions then draw keys from a small pool so that hits, updates and
// evictions are frequent. An internal table predicts every response and
// checks it field by field.
// ----------------------------------------------------------------------------
module lfu_cache_table_test;
	import lfu_pkg::*;

	localparam logic REQ_GET     = 1'b0;
	localparam logic REQ_SET     = 1'b1;
	localparam int   ENTRIES     = DefaultEntries;
	localparam int   CYCLE_LIMIT = 400000;
	localparam int   REPORT_MAX  = 10;
	localparam int   KEY_POOL    = 24;
	localparam int   PHASE_ITEMS = 130;

	class lfu_table_scoreboard;
		logic [KeyBits-1:0]   keys   [ENTRIES];
		logic [ValueBits-1:0] values [ENTRIES];
		logic [UsesBits-1:0]  counts [ENTRIES];
		int                   used;
		logic [CapBits-1:0]   cap;
		rsp_t                 awaited[$];
		int                   errors;

		function new();
			used   = 0;
			cap    = CapReset;
			errors = 0;
		endfunction

		function void set_capacity(logic [CapBits-1:0] v);
			cap = v;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void note_request(req_t r);
			rsp_t want;
			int   pos;
			int   least;
			int   limit;
			want = '0;
			pos  = -1;
			for (int i = 0; i < used; i++)
				if (pos < 0 && keys[i] == r.lookup_key) pos = i;
			if (pos >= 0) begin
				want.hit = 1'b1;
				if (counts[pos] != '1) counts[pos]++;
				if (r.req_type == REQ_SET) values[pos] = r.write_value;
				else want.read_value = values[pos];
			end else if (r.req_type == REQ_SET) begin
				limit = (cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : int'(cap);
				if (used >= limit && used > 0) begin
					least = 0;
					for (int i = 1; i < used; i++)
						if (counts[i] < counts[least]) least = i;
					want.evicted     = 1'b1;
					want.evicted_key = keys[least];
					for (int i = least; i + 1 < used; i++) begin
						keys[i]   = keys[i + 1];
						values[i] = values[i + 1];
						counts[i] = counts[i + 1];
					end
					used--;
				end
				if (used < ENTRIES) begin
					keys[used]   = r.lookup_key;
					values[used] = r.write_value;
					counts[used] = 1;
					used++;
				end
			end
			awaited.push_back(want);
		endfunction

		function void flag(string field, logic [63:0] want, logic [63:0] got);
			errors++;
			if (errors <= REPORT_MAX)
				$display("mismatch in %s: expected %h, got %h", field, want, got);
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("response with no transaction outstanding: %h", got);
				return;
			end
			want = awaited.pop_front();
			if (got.hit !== want.hit) flag("hit", want.hit, got.hit);
			if (got.read_value !== want.read_value)
				flag("read_value", want.read_value, got.read_value);
			if (got.evicted !== want.evicted) flag("evicted", want.evicted, got.evicted);
			if (got.evicted_key !== want.evicted_key)
				flag("evicted_key", want.evicted_key, got.evicted_key);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	req_t               req;
	logic               done;
	rsp_t               rsp;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CapBits-1:0] cfg_data;

	lfu_table_scoreboard sb;
	int                  idle_pct;
	int                  cycles;
	logic [KeyBits-1:0]  key_pool [KEY_POOL];

	lfu_cache_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done) sb.check_response(rsp);
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("lfu_cache_table_test: errors");
		$finish;
	end

	task automatic send_request(req_t r);
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_request(r);
		@(negedge clk);
	endtask

	task automatic idle_gap();
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
	endtask

	task automatic put(logic kind, logic [KeyBits-1:0] key, logic [ValueBits-1:0] value);
		req_t r;
		r.req_type    = kind;
		r.lookup_key  = key;
		r.write_value = value;
		send_request(r);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
		while (busy) @(negedge clk);
	endtask

	task automatic write_capacity(logic [CapBits-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_capacity(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic req_t random_request(int span);
		req_t r;
		r.req_type   = $urandom_range(1) ? REQ_SET : REQ_GET;
		r.lookup_key = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(span - 1)];
		case ($urandom_range(7))
			0: r.write_value = '0;
			1: r.write_value = '1;
			default: r.write_value = $urandom();
		endcase
		return r;
	endfunction

	task automatic run_directed();
		write_capacity(2);
		put(REQ_GET, 32'h0, 32'h0);
		put(REQ_SET, 32'h0, 32'hffff_ffff);
		put(REQ_GET, 32'h0, 32'h0);
		put(REQ_SET, 32'hffff_ffff, 32'h0);
		put(REQ_SET, 32'h0, 32'h5a5a_5a5a);
		put(REQ_GET, 32'hffff_ffff, 32'h0);
		put(REQ_GET, 32'h1234_5678, 32'hffff_0000);
		put(REQ_SET, 32'h1, 32'h1);
		put(REQ_SET, 32'h2, 32'h2);
		put(REQ_GET, 32'h2, 32'h0);
		put(REQ_GET, 32'h2, 32'h0);
		// equal counts: the older entry goes
		put(REQ_SET, 32'h3, 32'ha5a5_a5a5);
		wait_drained();
		write_capacity(16);
		put(REQ_SET, 32'h10, 32'h8000_0001);
		put(REQ_SET, 32'h11, 32'h7fff_fffe);
		put(REQ_SET, 32'h12, 32'h0000_ffff);
		wait_drained();
		// capacity below fill: replace one, fill unchanged
		write_capacity(1);
		put(REQ_SET, 32'h13, 32'h13);
		wait_drained();
		write_capacity(0);
		put(REQ_SET, 32'h14, 32'h14);
		wait_drained();
		write_capacity(31);
		put(REQ_SET, 32'h15, 32'h15);
		put(REQ_GET, 32'h14, 32'h0);
		wait_drained();
	endtask

	initial begin
		int caps  [8] = '{5, 16, 1, 31, 0, 9, 3, 12};
		int idles [4] = '{0, 84, 0, 38};
		int span;
		arst_n    = 1'b0;
		start     = 1'b0;
		req       = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		idle_pct  = 0;
		sb        = new();
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		run_directed();
		for (int p = 0; p < 8; p++) begin
			write_capacity(CapBits'(caps[p]));
			idle_pct = idles[p % 4];
			span = (caps[p] == 0) ? 1 : (caps[p] > ENTRIES) ? ENTRIES : caps[p];
			span = span + 4;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_request(random_request(span));
				idle_gap();
			end
			wait_drained();
		end
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("lfu_cache_table_test: clean");
		else
			$display("lfu_cache_table_test: errors");
		$finish;
	end

endmodule
